@@ sv/aled_pkg.sv @@
// Shared types and constants for the addressable LED frame encoder.
// No dependencies; used by aled_store and addressable_led_frame_encoder_top.
package aled_pkg;

    localparam int MAX_LEDS    = 256;
    localparam int LED_IDX_W   = $clog2(MAX_LEDS);
    localparam int LED_CNT_W   = 9;
    localparam int CNT_W       = ($clog2(MAX_LEDS + 1) > LED_CNT_W) ?
                                 $clog2(MAX_LEDS + 1) : LED_CNT_W;
    localparam int COLOR_W     = 24;
    localparam int CHAN_W      = 8;
    localparam int DUTY_W      = 10;
    localparam int RST_W       = 10;
    localparam int BIT_W       = 5;
    localparam int CFG_IDX_W   = 3;

    localparam logic [BIT_W-1:0]     LAST_BIT     = BIT_W'(COLOR_W - 1);
    localparam logic [LED_CNT_W-1:0] LED_COUNT_RV = 9'd8;
    localparam logic [DUTY_W-1:0]    ONE_TIME_RV  = 10'd66;
    localparam logic [DUTY_W-1:0]    ZERO_TIME_RV = 10'd33;
    localparam logic [DUTY_W-1:0]    MARKER_RV    = 10'd49;
    localparam logic [RST_W-1:0]     RST_PER_RV   = 10'd40;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_START = 2'd1,
        OP_TICK  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_START = 2'd1,
        PH_DATA  = 2'd2,
        PH_END   = 2'd3
    } phase_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LED_COUNT  = 3'd0,
        CFG_ONE_TIME   = 3'd1,
        CFG_ZERO_TIME  = 3'd2,
        CFG_MARKER     = 3'd3,
        CFG_RST_PER    = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic                 wr_en;
        logic [LED_IDX_W-1:0] wr_addr;
        logic [COLOR_W-1:0]   wr_data;
        logic                 rd_en;
        logic [LED_IDX_W-1:0] rd_addr;
    } store_req_t;

endpackage

@@ sv/aled_store.sv @@
// Color store: synchronous single-write/single-read memory with registered read data.
// Per-entry valid bits make unwritten entries read as zero after reset. Uses aled_pkg.
module aled_store
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  aled_pkg::store_req_t            req,
    output logic [aled_pkg::COLOR_W-1:0]    rd_data
);

    logic [aled_pkg::COLOR_W-1:0]  mem [aled_pkg::MAX_LEDS];
    logic [aled_pkg::MAX_LEDS-1:0] valid_reg;
    logic [aled_pkg::COLOR_W-1:0]  rd_word_reg;
    logic                          rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_word_reg <= mem[req.rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_valid_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_word_reg : '0;

endmodule

@@ sv/addressable_led_frame_encoder_top.sv @@
// Addressable LED frame encoder: command decode, frame sequencer and output register.
// Depends on aled_pkg and aled_store.
//
//  channel   dir  handshake               payload
//  input     in   in_valid / in_stall     opcode, led_index, red, green, blue
//  result    out  out_valid / out_stall   duty, line_active, busy_res, write_rejected,
//                                         frame_done, phase
//  config    in   cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One item per cycle sustained while out_stall is low; each item passes the store read, then the output register.
// Sequencer state updates on the accept edge, so back-to-back ticks need no interlock.
// Reset clears the sequencer and the store's valid bits, and loads the config registers with their reset values.
// in_stall rises only when both the read stage and the output register are full.
// cfg_ready is always high.
module addressable_led_frame_encoder_top
(
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [1:0]                           opcode,
    input  logic [7:0]                           led_index,
    input  logic [aled_pkg::CHAN_W-1:0]          red,
    input  logic [aled_pkg::CHAN_W-1:0]          green,
    input  logic [aled_pkg::CHAN_W-1:0]          blue,

    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [aled_pkg::DUTY_W-1:0]          duty,
    output logic                                 line_active,
    output logic                                 busy_res,
    output logic                                 write_rejected,
    output logic                                 frame_done,
    output logic [1:0]                           phase,

    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [aled_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [aled_pkg::DUTY_W-1:0]          cfg_data
);

    typedef struct packed {
        logic                           data_tick;
        logic [aled_pkg::BIT_W-1:0]     bit_pos;
        logic [aled_pkg::DUTY_W-1:0]    duty;
        logic [aled_pkg::DUTY_W-1:0]    one_time;
        logic [aled_pkg::DUTY_W-1:0]    zero_time;
        logic                           active;
        logic                           busy;
        logic                           rejected;
        logic                           done;
        aled_pkg::phase_t               phase;
    } stage_t;

    logic [aled_pkg::LED_CNT_W-1:0] led_count_reg;
    logic [aled_pkg::DUTY_W-1:0]    one_time_reg;
    logic [aled_pkg::DUTY_W-1:0]    zero_time_reg;
    logic [aled_pkg::DUTY_W-1:0]    marker_reg;
    logic [aled_pkg::RST_W-1:0]     rst_per_reg;

    aled_pkg::phase_t               phase_reg, phase_next;
    logic [aled_pkg::LED_IDX_W-1:0] led_cnt_reg, led_cnt_next;
    logic [aled_pkg::BIT_W-1:0]     bit_cnt_reg, bit_cnt_next;
    logic [aled_pkg::RST_W-1:0]     rst_cnt_reg, rst_cnt_next;

    logic                           s1_valid_reg;
    stage_t                         s1_reg, s1_next;

    logic                           out_valid_reg;
    logic [aled_pkg::DUTY_W-1:0]    duty_reg;
    logic                           active_reg;
    logic                           busy_reg;
    logic                           rejected_reg;
    logic                           done_reg;
    aled_pkg::phase_t               phase_out_reg;

    aled_pkg::op_t                  op;
    logic                           in_acc;
    logic                           out_en;
    logic [aled_pkg::CNT_W-1:0]     eff_count;
    logic [aled_pkg::RST_W-1:0]     eff_resets;
    logic [aled_pkg::CNT_W-1:0]     idx_ext;
    logic                           idx_ok;
    logic [aled_pkg::CNT_W-1:0]     led_inc;
    logic [aled_pkg::RST_W-1:0]     rst_inc;
    logic [aled_pkg::BIT_W-1:0]     bit_sel;
    aled_pkg::store_req_t           store_req;
    logic [aled_pkg::COLOR_W-1:0]   rd_word;

    assign op        = aled_pkg::op_t'(opcode);
    assign out_en    = !out_valid_reg || !out_stall;
    assign in_stall  = s1_valid_reg && !out_en;
    assign in_acc    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    assign eff_count  = (aled_pkg::CNT_W'(led_count_reg) > aled_pkg::CNT_W'(aled_pkg::MAX_LEDS)) ?
                        aled_pkg::CNT_W'(aled_pkg::MAX_LEDS) : aled_pkg::CNT_W'(led_count_reg);
    assign eff_resets = (rst_per_reg == '0) ? aled_pkg::RST_W'(1) : rst_per_reg;
    assign idx_ext    = aled_pkg::CNT_W'(led_index);
    assign idx_ok     = idx_ext < eff_count;
    assign led_inc    = aled_pkg::CNT_W'(led_cnt_reg) + aled_pkg::CNT_W'(1);
    assign rst_inc    = rst_cnt_reg + aled_pkg::RST_W'(1);
    assign bit_sel    = (bit_cnt_reg < aled_pkg::LAST_BIT) ? bit_cnt_reg : aled_pkg::LAST_BIT;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            led_count_reg <= aled_pkg::LED_COUNT_RV;
            one_time_reg  <= aled_pkg::ONE_TIME_RV;
            zero_time_reg <= aled_pkg::ZERO_TIME_RV;
            marker_reg    <= aled_pkg::MARKER_RV;
            rst_per_reg   <= aled_pkg::RST_PER_RV;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (aled_pkg::cfg_idx_t'(cfg_index))
                aled_pkg::CFG_LED_COUNT: led_count_reg <= cfg_data[aled_pkg::LED_CNT_W-1:0];
                aled_pkg::CFG_ONE_TIME:  one_time_reg  <= cfg_data;
                aled_pkg::CFG_ZERO_TIME: zero_time_reg <= cfg_data;
                aled_pkg::CFG_MARKER:    marker_reg    <= cfg_data;
                aled_pkg::CFG_RST_PER:   rst_per_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // frame sequencer: next state
    always_comb
    begin
        phase_next   = phase_reg;
        led_cnt_next = led_cnt_reg;
        bit_cnt_next = bit_cnt_reg;
        rst_cnt_next = rst_cnt_reg;
        if (in_acc)
        begin
            unique case (op)
                aled_pkg::OP_START:
                begin
                    if (phase_reg == aled_pkg::PH_IDLE)
                    begin
                        phase_next   = aled_pkg::PH_START;
                        led_cnt_next = '0;
                        bit_cnt_next = '0;
                        rst_cnt_next = '0;
                    end
                end
                aled_pkg::OP_TICK:
                begin
                    unique case (phase_reg)
                        aled_pkg::PH_START:
                        begin
                            if (rst_inc == '0 || rst_inc >= eff_resets)
                            begin
                                rst_cnt_next = '0;
                                led_cnt_next = '0;
                                bit_cnt_next = '0;
                                phase_next   = (eff_count == '0) ? aled_pkg::PH_END :
                                                                   aled_pkg::PH_DATA;
                            end
                            else
                            begin
                                rst_cnt_next = rst_inc;
                            end
                        end
                        aled_pkg::PH_DATA:
                        begin
                            if (bit_cnt_reg >= aled_pkg::LAST_BIT)
                            begin
                                bit_cnt_next = '0;
                                if (led_inc >= eff_count)
                                begin
                                    led_cnt_next = '0;
                                    rst_cnt_next = '0;
                                    phase_next   = aled_pkg::PH_END;
                                end
                                else
                                begin
                                    led_cnt_next = led_inc[aled_pkg::LED_IDX_W-1:0];
                                end
                            end
                            else
                            begin
                                bit_cnt_next = bit_cnt_reg + aled_pkg::BIT_W'(1);
                            end
                        end
                        aled_pkg::PH_END:
                        begin
                            if (rst_inc == '0 || rst_inc >= eff_resets)
                            begin
                                rst_cnt_next = '0;
                                phase_next   = aled_pkg::PH_IDLE;
                            end
                            else
                            begin
                                rst_cnt_next = rst_inc;
                            end
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    // frame sequencer: per-item results and store access
    always_comb
    begin
        s1_next.data_tick = (op == aled_pkg::OP_TICK) && (phase_reg == aled_pkg::PH_DATA);
        s1_next.bit_pos   = aled_pkg::LAST_BIT - bit_sel;
        s1_next.duty      = ((op == aled_pkg::OP_TICK) && (phase_reg == aled_pkg::PH_START) &&
                             (rst_cnt_reg == '0)) ? marker_reg : '0;
        s1_next.one_time  = one_time_reg;
        s1_next.zero_time = zero_time_reg;
        s1_next.active    = (op == aled_pkg::OP_TICK) && (phase_reg != aled_pkg::PH_IDLE);
        s1_next.busy      = phase_next != aled_pkg::PH_IDLE;
        s1_next.rejected  = (op == aled_pkg::OP_WRITE) && !idx_ok;
        s1_next.done      = (op == aled_pkg::OP_TICK) && (phase_reg == aled_pkg::PH_END) &&
                            (phase_next == aled_pkg::PH_IDLE);
        s1_next.phase     = (op == aled_pkg::OP_START) ? phase_next : phase_reg;

        store_req.wr_en   = in_acc && (op == aled_pkg::OP_WRITE) && idx_ok;
        store_req.wr_addr = aled_pkg::LED_IDX_W'(led_index);
        store_req.wr_data = {green, red, blue};
        store_req.rd_en   = in_acc && s1_next.data_tick;
        store_req.rd_addr = led_cnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= aled_pkg::PH_IDLE;
            led_cnt_reg <= '0;
            bit_cnt_reg <= '0;
            rst_cnt_reg <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            led_cnt_reg <= led_cnt_next;
            bit_cnt_reg <= bit_cnt_next;
            rst_cnt_reg <= rst_cnt_next;
        end
    end

    aled_store u_store
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (store_req),
        .rd_data (rd_word)
    );

    // read stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_acc)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (out_en)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_reg <= s1_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_en)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_en && s1_valid_reg)
        begin
            duty_reg      <= s1_reg.data_tick ?
                             (rd_word[s1_reg.bit_pos] ? s1_reg.one_time : s1_reg.zero_time) :
                             s1_reg.duty;
            active_reg    <= s1_reg.active;
            busy_reg      <= s1_reg.busy;
            rejected_reg  <= s1_reg.rejected;
            done_reg      <= s1_reg.done;
            phase_out_reg <= s1_reg.phase;
        end
    end

    assign out_valid      = out_valid_reg;
    assign duty           = duty_reg;
    assign line_active    = active_reg;
    assign busy_res       = busy_reg;
    assign write_rejected = rejected_reg;
    assign frame_done     = done_reg;
    assign phase          = phase_out_reg;

endmodule
